/* rtl/core/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* rtl/core/edec_pkg.sv */
// package with types, constants and codes of the elgamal decrypt unit
package edec_pkg;

    // datapath width and multiplier bit counter width
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 1'd1;

    // multiplier operand selection and write-back codes
    localparam logic [1:0] MUL_RED = 2'd0;   // 1 * a, reduces a below p
    localparam logic [1:0] MUL_ACC = 2'd1;   // acc * sq
    localparam logic [1:0] MUL_SQ  = 2'd2;   // sq * sq
    localparam logic [1:0] MUL_FIN = 2'd3;   // s_inv * b

    // input word
    typedef struct packed {
        logic [31:0] cipher_a;
        logic [31:0] cipher_b;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [31:0] plain_value;
        logic [7:0]  plain_byte;
    } out_word_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [1:0] sel;
        logic       mul_wb;
        logic       exp_shift;
        logic       phase2;
        logic       out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic exp_upper_zero;
        logic p_small;
    } stat_t;

endpackage

/* rtl/core/edec_modmul.sv */
// serial shift-add modular multiplier, one multiplier bit per cycle
module edec_modmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [edec_pkg::WIDTH-1:0] u,
    input  logic [edec_pkg::WIDTH-1:0] v,
    input  logic [edec_pkg::WIDTH-1:0] p,
    output logic                      busy,
    output logic                      done,
    output logic [edec_pkg::WIDTH-1:0] result
);

    localparam int W = edec_pkg::WIDTH;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [edec_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      u_reg;
    logic [W-1:0]      v_reg;

    logic [W:0] dbl;
    logic [W:0] red1;
    logic [W:0] addend;
    logic [W:0] sum;
    logic [W:0] red2;

    // one step: acc = 2*acc mod p, then add u mod p when the current bit is set
    always_comb
    begin
        dbl    = {acc_reg, 1'b0};
        red1   = (dbl >= {1'b0, p}) ? (dbl - {1'b0, p}) : dbl;
        addend = v_reg[W-1] ? {1'b0, u_reg} : '0;
        sum    = red1 + addend;
        red2   = (sum >= {1'b0, p}) ? (sum - {1'b0, p}) : sum;
    end

    // control next state
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == edec_pkg::CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // accumulator next value
    always_comb
    begin
        acc_next = acc_reg;
        if (start)
            acc_next = '0;
        else if (busy_reg)
            acc_next = red2[W-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            u_reg <= u;
            v_reg <= v;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[W-2:0], 1'b0};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* rtl/core/edec_datapath.sv */
// datapath: configuration, operand registers, multiplier and output register
module edec_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [edec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  edec_pkg::in_word_t                 in_data,
    input  edec_pkg::cmd_t                     cmd,
    output edec_pkg::stat_t                    stat,
    output edec_pkg::out_word_t                out_data
);

    localparam int W = edec_pkg::WIDTH;

    logic [W-1:0] modulus_reg;
    logic [W-1:0] priv_exp_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] sq_reg;
    logic [W-1:0] exp_reg;
    logic [W-1:0] out_reg;

    logic [W-1:0] mul_u;
    logic [W-1:0] mul_v;
    logic [W-1:0] mul_res;
    logic         mul_busy;
    logic         mul_done;
    logic         p_small;

    assign p_small = (modulus_reg < W'(2));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= W'(3);
            priv_exp_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                edec_pkg::CFG_MODULUS:  modulus_reg  <= cfg_data[W-1:0];
                edec_pkg::CFG_PRIV_EXP: priv_exp_reg <= cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    // multiplier operand selection
    always_comb
    begin
        unique case (cmd.sel)
            edec_pkg::MUL_RED:
            begin
                mul_u = W'(1);
                mul_v = a_reg;
            end
            edec_pkg::MUL_ACC:
            begin
                mul_u = acc_reg;
                mul_v = sq_reg;
            end
            edec_pkg::MUL_SQ:
            begin
                mul_u = sq_reg;
                mul_v = sq_reg;
            end
            default:
            begin
                mul_u = acc_reg;
                mul_v = b_reg;
            end
        endcase
    end

    edec_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .u      (mul_u),
        .v      (mul_v),
        .p      (modulus_reg),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_res)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= in_data.cipher_a;
            b_reg   <= in_data.cipher_b;
            exp_reg <= priv_exp_reg;
            acc_reg <= p_small ? '0 : W'(1);
        end
        else if (cmd.phase2)
        begin
            sq_reg  <= acc_reg;
            acc_reg <= W'(1);
            exp_reg <= modulus_reg - W'(2);
        end
        else
        begin
            if (cmd.mul_wb)
            begin
                unique case (cmd.sel)
                    edec_pkg::MUL_RED: sq_reg  <= mul_res;
                    edec_pkg::MUL_ACC: acc_reg <= mul_res;
                    edec_pkg::MUL_SQ:  sq_reg  <= mul_res;
                    default:           acc_reg <= mul_res;
                endcase
            end
            if (cmd.exp_shift)
                exp_reg <= {1'b0, exp_reg[W-1:1]};
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= acc_reg;
    end

    assign out_data.plain_value = 32'(out_reg);
    assign out_data.plain_byte  = out_reg[7:0];

    // status to the controller
    assign stat.mul_busy       = mul_busy;
    assign stat.mul_done       = mul_done;
    assign stat.exp_zero       = (exp_reg == '0);
    assign stat.exp_lsb        = exp_reg[0];
    assign stat.exp_upper_zero = (exp_reg[W-1:1] == '0);
    assign stat.p_small        = p_small;

endmodule

/* rtl/core/edec_ctrl.sv */
// controller state machine sequencing the two exponentiations and the final product
module edec_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  edec_pkg::stat_t  stat,
    output edec_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.sel        = sel_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    if (stat.p_small)
                        state_next = S_DONE;
                    else
                    begin
                        sel_next   = edec_pkg::MUL_RED;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.mul_wb = 1'b1;
                    unique case (sel_reg)
                        edec_pkg::MUL_RED: state_next = S_CHECK;
                        edec_pkg::MUL_SQ:  state_next = S_CHECK;
                        edec_pkg::MUL_ACC:
                        begin
                            // skip the square once the exponent runs out
                            cmd.exp_shift = 1'b1;
                            if (stat.exp_upper_zero)
                                state_next = S_CHECK;
                            else
                            begin
                                sel_next   = edec_pkg::MUL_SQ;
                                state_next = S_START;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (stat.exp_zero)
                begin
                    if (!phase_reg)
                    begin
                        // shared secret done: start the inverse exponentiation
                        cmd.phase2 = 1'b1;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        sel_next   = edec_pkg::MUL_FIN;
                        state_next = S_START;
                    end
                end
                else if (stat.exp_lsb)
                begin
                    sel_next   = edec_pkg::MUL_ACC;
                    state_next = S_START;
                end
                else
                begin
                    cmd.exp_shift = 1'b1;
                    sel_next      = edec_pkg::MUL_SQ;
                    state_next    = S_START;
                end
            end
            S_DONE:
            begin
                // hand the word over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= edec_pkg::MUL_RED;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/elgamal_decrypt_unit.sv */
// top level of the elgamal decrypt unit
// Decrypts one ciphertext word (cipher_a, cipher_b) at a time with the modulus p
// and private exponent x from the configuration registers: s = a^x mod p,
// s_inv = s^(p-2) mod p, plain_value = b * s_inv mod p, plain_byte its low
// eight bits; a modulus below two gives zero. All products go through one
// serial modular multiplier, one product after another; the two exponentiations
// are square-and-multiply passes over the bits of x and of p-2, and the words
// are processed one at a time. A finished word waits in the output register
// while the next one is accepted and worked on.
module elgamal_decrypt_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  edec_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output edec_pkg::out_word_t            out_data,
    input  logic                           cfg_we,
    input  logic [edec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    edec_pkg::cmd_t  cmd;
    edec_pkg::stat_t stat;

    edec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    edec_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // checks
`include "assert_macros.svh"

    `ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_mul_start_when_free, cmd.mul_start, !stat.mul_busy)
    `ASSERT_SAME(a_idle_mul_quiet, in_ready, !stat.mul_busy && !cmd.mul_start)

endmodule

/* bench/edec_checker.sv */
// result checker for the elgamal decrypt unit: predicts each plaintext word and compares
`timescale 1ns / 100ps

module edec_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  edec_pkg::in_word_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  edec_pkg::out_word_t            out_data,
    input  logic                           cfg_we,
    input  logic [edec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             words_done
);

    // shadow copies of the modulus and private exponent registers
    logic [31:0] modulus_reg;
    logic [31:0] exponent_reg;

    // plaintext words still owed by the block, oldest first
    edec_pkg::out_word_t plain_expected[$];

    // product of two residues; operands stay below 2^32 so 64 bits hold it
    function automatic logic [63:0] mul_mod(input logic [63:0] u, input logic [63:0] v,
                                            input logic [63:0] m);
        return ((u % m) * (v % m)) % m;
    endfunction

    // right-to-left square-and-multiply
    function automatic logic [63:0] pow_mod(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = base % m;
        while (e != 64'd0)
        begin
            if (e[0])
                acc = mul_mod(acc, sq, m);
            e  = e >> 1;
            sq = mul_mod(sq, sq, m);
        end
        return acc;
    endfunction

    // shared secret, fermat inverse, then unmask cipher_b; modulus below two gives zero
    function automatic edec_pkg::out_word_t decrypt_pair(input edec_pkg::in_word_t w,
                                                         input logic [31:0] p,
                                                         input logic [31:0] x);
        edec_pkg::out_word_t r;
        logic [63:0]         secret;
        logic [63:0]         secret_inv;
        logic [63:0]         plain;
        plain = 64'd0;
        if (p >= 32'd2)
        begin
            secret     = pow_mod(64'(w.cipher_a), 64'(x), 64'(p));
            secret_inv = pow_mod(secret, 64'(p - 32'd2), 64'(p));
            plain      = mul_mod(64'(w.cipher_b), secret_inv, 64'(p));
        end
        r.plain_value = plain[31:0];
        r.plain_byte  = plain[7:0];
        return r;
    endfunction

    // watch config writes, accepted ciphertext words and returned plaintext words
    always @(posedge clk or negedge rst_n)
    begin : watch
        edec_pkg::out_word_t want;
        if (!rst_n)
        begin
            modulus_reg  <= 32'd3;
            exponent_reg <= 32'd0;
            plain_expected.delete();
            fail_count <= 0;
            pending    <= 0;
            words_done <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    edec_pkg::CFG_MODULUS:  modulus_reg  <= cfg_data;
                    edec_pkg::CFG_PRIV_EXP: exponent_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                plain_expected = {plain_expected,
                                  decrypt_pair(in_data, modulus_reg, exponent_reg)};

            if (out_valid && out_ready)
            begin
                words_done <= words_done + 1;
                if (plain_expected.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected plaintext word value %h byte %h",
                                 $realtime, out_data.plain_value, out_data.plain_byte);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = plain_expected.pop_front();
                    if (out_data.plain_value !== want.plain_value ||
                        out_data.plain_byte !== want.plain_byte)
                    begin
                        if (fail_count < 10)
                            $display("%0t: word %0d value exp %h got %h, byte exp %h got %h",
                                     $realtime, words_done, want.plain_value,
                                     out_data.plain_value, want.plain_byte, out_data.plain_byte);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            pending <= plain_expected.size();
        end
    end

endmodule

/* bench/elgamal_decrypt_unit_tb.sv */
// testbench top for the elgamal decrypt unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module elgamal_decrypt_unit_tb;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int LONG_HOLD     = 8000;
    localparam int SETTLE_CYCLES = 5000;
    localparam int RANDOM_WORDS  = 110;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    edec_pkg::in_word_t             in_data;
    logic                           out_valid;
    logic                           out_ready;
    edec_pkg::out_word_t            out_data;
    logic                           cfg_we;
    logic [edec_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    int fail_count;
    int pending;
    int words_done;

    // register values currently loaded, starting from their reset values
    logic [31:0] cur_p = 32'd3;
    logic [31:0] cur_x = 32'd0;

    int  cycle_count  = 0;
    int  words_sent   = 0;
    int  random_sent  = 0;
    int  settings     = 0;
    int  long_holds   = 0;
    bit  hold_request = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    elgamal_decrypt_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    edec_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .words_done (words_done)
    );

    // modular power, only used to build well-formed ciphertexts
    function automatic logic [63:0] raise_mod(input logic [63:0] base, input logic [63:0] e,
                                              input logic [63:0] m);
        logic [63:0] r;
        r    = 64'd1 % m;
        base = base % m;
        for (int i = 0; i < 32; i++)
        begin
            if (e[i])
                r = (r * base) % m;
            base = (base * base) % m;
        end
        return r;
    endfunction

    function automatic logic [31:0] known_prime(input int k);
        case (k)
            0:       return 32'd3;
            1:       return 32'd5;
            2:       return 32'd7;
            3:       return 32'd13;
            4:       return 32'd251;
            5:       return 32'd257;
            6:       return 32'd65521;
            7:       return 32'd65537;
            8:       return 32'd1000003;
            9:       return 32'd16777213;
            10:      return 32'd2147483647;
            default: return 32'd4294967291;
        endcase
    endfunction

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // offer one ciphertext word and hold it until accepted
    task automatic send_word(input edec_pkg::in_word_t w, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // stop offering and wait until every plaintext word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // write both registers on consecutive edges
    task automatic load_regs(input logic [31:0] p, input logic [31:0] x);
        cfg_we    <= 1'b1;
        cfg_index <= edec_pkg::CFG_MODULUS;
        cfg_data  <= p;
        @(posedge clk);
        cfg_index <= edec_pkg::CFG_PRIV_EXP;
        cfg_data  <= x;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_p = p;
        cur_x = x;
        settings++;
    endtask

    // one hand-picked word, reloading the registers when the setting changes
    task automatic directed_word(input logic [31:0] p, input logic [31:0] x,
                                 input logic [31:0] a, input logic [31:0] b);
        edec_pkg::in_word_t w;
        if (p !== cur_p || x !== cur_x)
        begin
            drain_results();
            load_regs(p, x);
        end
        w.cipher_a = a;
        w.cipher_b = b;
        send_word(w, pick_gap($urandom_range(0, 1) == 0));
    endtask

    // mostly genuine ciphertexts of random characters, the rest raw noise
    task automatic random_phase(input logic [31:0] p, input logic [31:0] x, input int count,
                                input bit with_hold);
        bit                 calm;
        edec_pkg::in_word_t w;
        logic [31:0]        ch;
        logic [63:0]        masked;
        calm = ($urandom_range(0, 2) == 0);
        drain_results();
        load_regs(p, x);
        if (with_hold)
            hold_request = 1'b1;
        repeat (count)
        begin
            if (p >= 32'd3 && $urandom_range(0, 9) < 7)
            begin
                w.cipher_a = $urandom_range(1, p - 1);
                ch         = $urandom_range(0, 255) % p;
                masked     = (64'(ch) * raise_mod(64'(w.cipher_a), 64'(x), 64'(p))) % 64'(p);
                w.cipher_b = masked[31:0];
            end
            else
            begin
                w.cipher_a = $urandom;
                w.cipher_b = $urandom;
            end
            send_word(w, pick_gap(calm));
            random_sent++;
        end
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial
    begin : result_sink
        int gap;
        int stretch;
        bit calm;
        out_ready = 1'b0;
        stretch   = 0;
        calm      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stretch == 0)
            begin
                calm    = ($urandom_range(0, 2) == 0);
                stretch = $urandom_range(8, 24);
            end
            stretch--;
            if (hold_request)
            begin
                gap          = LONG_HOLD;
                hold_request = 1'b0;
                long_holds++;
            end
            else
                gap = pick_gap(calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [31:0] p;
        logic [31:0] x;
        int          bits;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = edec_pkg::CFG_MODULUS;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: p = 3, x = 0
        directed_word(32'd3, 32'd0, 32'd5, 32'd7);
        directed_word(32'd3, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // largest 32-bit prime, all-ones exponent: zero secret, inputs at or above p
        directed_word(32'd4294967291, 32'hFFFF_FFFF, 32'd0, 32'd12345);
        directed_word(32'd4294967291, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        directed_word(32'd4294967291, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4294967291);
        directed_word(32'd4294967291, 32'hFFFF_FFFF, 32'd4294967291, 32'd1);
        directed_word(32'd4294967291, 32'hFFFF_FFFF, 32'd2, 32'h41);
        // exponent zero: secret is one
        directed_word(32'd4294967291, 32'd0, 32'h1234_5678, 32'hFFFF_FFFE);
        directed_word(32'd4294967291, 32'd0, 32'd0, 32'd0);
        // modulus zero and one give zero
        directed_word(32'd0, 32'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed_word(32'd1, 32'h1234, 32'hABCD, 32'd9);
        // modulus two: inverse is one
        directed_word(32'd2, 32'd5, 32'd3, 32'd3);
        directed_word(32'd2, 32'd5, 32'd2, 32'd7);
        // all-ones modulus, alternating bit patterns
        directed_word(32'hFFFF_FFFF, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555);
        directed_word(32'hFFFF_FFFF, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
        directed_word(32'd3, 32'd1, 32'd2, 32'd2);
        directed_word(32'd7, 32'd3, 32'd0, 32'd6);

        // a quick setting with a long output stall so the input backs up
        random_phase(32'd65521, $urandom & 32'h0000_FFFF, 24, 1'b1);

        // random settings, mostly small moduli and exponents
        while (random_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 3)) inside
                0:       p = known_prime($urandom_range(0, 11));
                1, 2:
                begin
                    bits = $urandom_range(2, 20);
                    p    = ($urandom >> (32 - bits)) | (32'd1 << (bits - 1));
                end
                default: p = $urandom | 32'h8000_0000;
            endcase
            if (p < 32'd3)
                p = 32'd3;
            bits = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(0, 20);
            x    = (bits == 0) ? 32'd0 : ($urandom >> (32 - bits));
            random_phase(p, x, $urandom_range(8, 20), 1'b0);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("decrypted %0d ciphertext words (%0d random) under %0d register settings",
                 words_sent, random_sent, settings);
        $display("plaintext words checked: %0d, long output stalls: %0d, mismatches: %0d",
                 words_done, long_holds, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/edec_pkg.sv
rtl/core/edec_modmul.sv
rtl/core/edec_datapath.sv
rtl/core/edec_ctrl.sv
rtl/core/elgamal_decrypt_unit.sv
bench/edec_checker.sv
bench/elgamal_decrypt_unit_tb.sv
